// ----- rtl/core/sfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the sensor
// frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Header and tail markers
    localparam logic [7:0] HDR_START    = 8'h01;
    localparam logic [7:0] HDR_ID_LIMIT = 8'h0A;
    localparam logic [7:0] HDR_SYNC     = 8'hAA;
    localparam logic [7:0] TAIL_MARK    = 8'h55;

    // Frame length limits
    localparam logic [7:0] MIN_FRAME = 8'd6;
    localparam logic [7:0] MAX_FRAME = 8'd64;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Result queue geometry
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int RUN_MAX    = 4;

    // One result beat
    typedef struct packed {
        logic       frame_good;
        logic       frame_end;
        logic       run_last;
        logic [7:0] byte_index;
        logic [7:0] frame_byte;
    } result_t;

    // Reflected CRC-16 update by one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- rtl/core/sfd_result_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_result_fifo
// Small result queue: takes up to four beats per cycle, hands out one beat
// per cycle on the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module sfd_result_fifo
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [2:0]                              push_count,
    input  sfd_pkg::result_t [sfd_pkg::RUN_MAX-1:0] push_data,
    output logic                                    room,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output sfd_pkg::result_t                        out_data
);

    sfd_pkg::result_t              mem_reg [sfd_pkg::FIFO_DEPTH];
    logic [sfd_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [sfd_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [sfd_pkg::FIFO_AW:0]     count_reg;
    logic [sfd_pkg::FIFO_AW:0]     count_next;
    logic                          pop;

    // Room for a full run of beats, judged on the registered fill
    assign room = (count_reg <= (sfd_pkg::FIFO_AW+1)'(sfd_pkg::FIFO_DEPTH - sfd_pkg::RUN_MAX));

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign count_next = count_reg + (sfd_pkg::FIFO_AW+1)'(push_count)
                        - (sfd_pkg::FIFO_AW+1)'(pop);

    // Store pushed beats in order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sfd_pkg::RUN_MAX; i++)
        begin
            if (3'(i) < push_count)
                mem_reg[wr_ptr_reg + sfd_pkg::FIFO_AW'(i)] <= push_data[i];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + sfd_pkg::FIFO_AW'(push_count);
            rd_ptr_reg <= rd_ptr_reg + sfd_pkg::FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/sensor_frame_deframer_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_crc16
// Hunts a byte stream for a frame header, passes the frame through with its
// byte index and checks CRC-16/MODBUS and the tail byte.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tdata[7:0] frame_byte, [15:8] byte_index; tlast run_last;
//                 tuser[0] frame_end, [1] frame_good
//
// One input byte is taken per cycle while s_axis_tready is high. A header
// byte makes four output beats, a frame byte one, a hunting byte none. Beats
// go into an 8-entry result queue; s_axis_tready is high while the queue has
// room for four beats, so a stalled output stops input once five are queued.
// Reset clears to hunting with an empty queue.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_crc16
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] frame_byte, [15:8] byte_index
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [0] frame_end, [1] frame_good
);

    logic [7:0]  hist0_reg, hist1_reg, hist2_reg;
    logic [7:0]  hist0_next, hist1_next, hist2_next;
    logic        collecting_reg, collecting_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [15:0] crc_reg, crc_next;
    logic        check_ok_reg, check_ok_next;

    logic        accept;
    logic [7:0]  rx;
    logic        header_hit;
    logic [8:0]  k_ext;
    logic [8:0]  len_ext;
    logic        crc_en;
    logic        chk_lo, chk_hi, at_end;
    logic [15:0] crc_sync;
    logic        good;
    logic [2:0]  push_count;

    sfd_pkg::result_t [sfd_pkg::RUN_MAX-1:0] push_data;
    sfd_pkg::result_t                        out_data;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign rx     = s_axis_tdata;

    // Header match on history plus the length byte
    assign header_hit = !collecting_reg
                        && (hist0_reg == sfd_pkg::HDR_START)
                        && (hist1_reg <  sfd_pkg::HDR_ID_LIMIT)
                        && (hist2_reg == sfd_pkg::HDR_SYNC)
                        && (rx >= sfd_pkg::MIN_FRAME)
                        && (rx <= sfd_pkg::MAX_FRAME);

    // Position tests for a frame byte
    assign k_ext   = {1'b0, byte_count_reg};
    assign len_ext = {1'b0, frame_length_reg};
    assign crc_en  = (k_ext + 9'd4) <= len_ext;
    assign chk_lo  = (k_ext + 9'd3) == len_ext;
    assign chk_hi  = (k_ext + 9'd2) == len_ext;
    assign at_end  = (k_ext + 9'd1) == len_ext;
    assign good    = at_end && check_ok_reg && (rx == sfd_pkg::TAIL_MARK);

    // CRC after the sync byte at index 2 (constant)
    assign crc_sync = sfd_pkg::crc16_byte(sfd_pkg::CRC_INIT, sfd_pkg::HDR_SYNC);

    // Next state and result beats
    always_comb
    begin
        hist0_next        = hist0_reg;
        hist1_next        = hist1_reg;
        hist2_next        = hist2_reg;
        collecting_next   = collecting_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        crc_next          = crc_reg;
        check_ok_next     = check_ok_reg;
        push_count        = 3'd0;

        push_data[0] = '{frame_good: 1'b0, frame_end: 1'b0, run_last: 1'b0,
                         byte_index: 8'd0, frame_byte: sfd_pkg::HDR_START};
        push_data[1] = '{frame_good: 1'b0, frame_end: 1'b0, run_last: 1'b0,
                         byte_index: 8'd1, frame_byte: hist1_reg};
        push_data[2] = '{frame_good: 1'b0, frame_end: 1'b0, run_last: 1'b0,
                         byte_index: 8'd2, frame_byte: sfd_pkg::HDR_SYNC};
        push_data[3] = '{frame_good: 1'b0, frame_end: 1'b0, run_last: 1'b1,
                         byte_index: 8'd3, frame_byte: rx};

        if (collecting_reg)
        begin
            // Pass one frame byte through
            push_data[0] = '{frame_good: good, frame_end: at_end, run_last: 1'b1,
                             byte_index: byte_count_reg, frame_byte: rx};
            if (accept)
            begin
                push_count      = 3'd1;
                byte_count_next = byte_count_reg + 8'd1;
                if (crc_en)
                    crc_next = sfd_pkg::crc16_byte(crc_reg, rx);
                if ((chk_lo && rx != crc_reg[7:0]) || (chk_hi && rx != crc_reg[15:8]))
                    check_ok_next = 1'b0;
                if (at_end)
                begin
                    collecting_next = 1'b0;
                    byte_count_next = 8'd0;
                    hist0_next      = 8'd0;
                    hist1_next      = 8'd0;
                    hist2_next      = 8'd0;
                end
            end
        end
        else if (accept)
        begin
            if (header_hit)
            begin
                // Emit the header run and start collecting
                push_count        = 3'd4;
                frame_length_next = rx;
                collecting_next   = 1'b1;
                byte_count_next   = 8'd4;
                hist0_next        = 8'd0;
                hist1_next        = 8'd0;
                hist2_next        = 8'd0;
                if (rx == sfd_pkg::MIN_FRAME)
                begin
                    crc_next      = crc_sync;
                    check_ok_next = (rx == crc_sync[7:0]);
                end
                else
                begin
                    crc_next      = sfd_pkg::crc16_byte(crc_sync, rx);
                    check_ok_next = 1'b1;
                end
            end
            else
            begin
                // Shift the hunting history
                hist0_next = hist1_reg;
                hist1_next = hist2_reg;
                hist2_next = rx;
            end
        end
    end

    // Hold deframer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg        <= 8'd0;
            hist1_reg        <= 8'd0;
            hist2_reg        <= 8'd0;
            collecting_reg   <= 1'b0;
            byte_count_reg   <= 8'd0;
            frame_length_reg <= 8'd0;
            crc_reg          <= sfd_pkg::CRC_INIT;
            check_ok_reg     <= 1'b1;
        end
        else
        begin
            hist0_reg        <= hist0_next;
            hist1_reg        <= hist1_next;
            hist2_reg        <= hist2_next;
            collecting_reg   <= collecting_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            crc_reg          <= crc_next;
            check_ok_reg     <= check_ok_next;
        end
    end

    // Queue result beats toward the output
    sfd_result_fifo u_result_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (push_data),
        .room       (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tdata = {out_data.byte_index, out_data.frame_byte};
    assign m_axis_tlast = out_data.run_last;
    assign m_axis_tuser = {out_data.frame_good, out_data.frame_end};

endmodule

// ----- sim/tb_sensor_frame_deframer_crc16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_crc16
// Feeds the deframer a byte stream of noise, broken headers and CRC-16/MODBUS
// frames, good and damaged. A shadow deframer works out the output beats of
// every accepted byte, and each output beat is checked against the oldest of
// them. Both sides idle and stall at random across several phases.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_crc16;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 320;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 30;
    localparam int FRAME_CAP     = 256;

    // Idle and stall chances, in percent, of the random phases
    localparam int SENDER_IDLE [4]    = '{0, 51, 0, 27};
    localparam int RECEIVER_STALL [4] = '{0, 0, 51, 27};

    // Damage applied to a generated frame
    typedef enum int
    {
        FLAW_NONE,
        FLAW_CRC_LO,
        FLAW_CRC_HI,
        FLAW_TAIL,
        FLAW_PAYLOAD
    } flaw_e;

    // One byte waiting to be sent, with the pacing it is sent under
    typedef struct {
        logic [7:0] data;
        int         idle_pct;
        int         stall_pct;
        bit         drain;
    } rx_item_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] frame_byte, [15:8] byte_index
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;            // [0] frame_end, [1] frame_good

    rx_item_t          rx_stream[$];
    sfd_pkg::result_t  expected_beats[$];

    // Pacing attached to bytes as the stream is built
    int build_idle;
    int build_stall;
    bit build_drain;
    int stall_pct = 0;

    // Shadow deframer state
    logic [7:0]  hunt_hist [3];
    bit          in_frame;
    logic [7:0]  frame_pos;
    logic [7:0]  frame_len;
    logic [15:0] crc_run;
    bit          checks_ok;

    int bytes_accepted = 0;
    int beats_checked  = 0;
    int frames_ended   = 0;
    int frames_good    = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    sensor_frame_deframer_crc16 dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-16 update, LSB first
    function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ sfd_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Take one frame byte at index k: advance CRC and checks, build its beat
    function automatic sfd_pkg::result_t frame_beat(logic [7:0] b, int k);
        sfd_pkg::result_t r;
        int               len;
        len = frame_len;
        if (k >= 2 && k + 4 <= len)
            crc_run = crc16_modbus_step(crc_run, b);
        if (k + 3 == len && b != crc_run[7:0])
            checks_ok = 1'b0;
        if (k + 2 == len && b != crc_run[15:8])
            checks_ok = 1'b0;
        r.frame_byte = b;
        r.byte_index = 8'(k);
        r.run_last   = 1'b0;
        r.frame_end  = (k + 1 == len);
        r.frame_good = r.frame_end && checks_ok && (b == sfd_pkg::TAIL_MARK);
        return r;
    endfunction

    // Predict the beats caused by one accepted byte
    task automatic deframe_byte(logic [7:0] b);
        sfd_pkg::result_t r;
        if (in_frame)
        begin
            r = frame_beat(b, frame_pos);
            r.run_last = 1'b1;
            expected_beats.push_back(r);
            frame_pos = frame_pos + 8'd1;
            if (r.frame_end)
            begin
                in_frame  = 1'b0;
                frame_pos = 8'd0;
                hunt_hist = '{default: 8'h00};
            end
        end
        else if (hunt_hist[0] == sfd_pkg::HDR_START && hunt_hist[1] < sfd_pkg::HDR_ID_LIMIT &&
                 hunt_hist[2] == sfd_pkg::HDR_SYNC && b >= sfd_pkg::MIN_FRAME &&
                 b <= sfd_pkg::MAX_FRAME)
        begin
            // Header found: replay all four header bytes as one run
            frame_len = b;
            crc_run   = sfd_pkg::CRC_INIT;
            checks_ok = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                r = frame_beat((k < 3) ? hunt_hist[k] : b, k);
                r.run_last = (k == 3);
                expected_beats.push_back(r);
            end
            frame_pos = 8'd4;
            in_frame  = 1'b1;
            hunt_hist = '{default: 8'h00};
        end
        else
        begin
            hunt_hist[0] = hunt_hist[1];
            hunt_hist[1] = hunt_hist[2];
            hunt_hist[2] = b;
        end
    endtask

    task automatic add_byte(logic [7:0] b);
        rx_item_t it;
        it.data      = b;
        it.idle_pct  = build_idle;
        it.stall_pct = build_stall;
        it.drain     = build_drain;
        build_drain  = 1'b0;
        rx_stream.push_back(it);
    endtask

    task automatic add_header(logic [7:0] id, logic [7:0] len);
        add_byte(sfd_pkg::HDR_START);
        add_byte(id);
        add_byte(sfd_pkg::HDR_SYNC);
        add_byte(len);
    endtask

    // Build a whole frame with correct CRC and tail, then damage it as asked
    task automatic add_frame(int len, logic [7:0] id, flaw_e flaw, bit nest_header);
        logic [7:0]  f [FRAME_CAP];
        logic [15:0] crc;
        logic [7:0]  mask;
        int          spot;
        f[0] = sfd_pkg::HDR_START;
        f[1] = id;
        f[2] = sfd_pkg::HDR_SYNC;
        f[3] = 8'(len);
        for (int i = 4; i < len; i++)
            f[i] = 8'($urandom_range(255));
        // Plant a header pattern inside the payload; it must pass as data
        if (nest_header && len >= 11)
        begin
            spot = $urandom_range(4, len - 7);
            f[spot]     = sfd_pkg::HDR_START;
            f[spot + 1] = 8'h00;
            f[spot + 2] = sfd_pkg::HDR_SYNC;
            f[spot + 3] = sfd_pkg::MIN_FRAME + 8'd2;
        end
        crc = sfd_pkg::CRC_INIT;
        for (int i = 2; i + 4 <= len; i++)
            crc = crc16_modbus_step(crc, f[i]);
        // At the minimum length the CRC low byte slot is the length byte
        if (len > 6)
            f[len - 3] = crc[7:0];
        f[len - 2] = crc[15:8];
        f[len - 1] = sfd_pkg::TAIL_MARK;
        mask = 8'h01 << $urandom_range(7);
        case (flaw)
            FLAW_CRC_LO:  if (len > 6) f[len - 3] ^= mask;
            FLAW_CRC_HI:  f[len - 2] ^= mask;
            FLAW_TAIL:    f[len - 1] ^= mask;
            FLAW_PAYLOAD: if (len >= 8) f[$urandom_range(4, len - 4)] ^= mask;
            default:      ;
        endcase
        for (int i = 0; i < len; i++)
            add_byte(f[i]);
    endtask

    // Send bytes from the stream, predicting each as it is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata);
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (rx_stream.size() != 0 &&
                    !(rx_stream[0].drain && expected_beats.size() != 0) &&
                    $urandom_range(99) >= rx_stream[0].idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_stream[0].data;
                    stall_pct     <= rx_stream[0].stall_pct;
                    void'(rx_stream.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Check each output beat against the oldest prediction
    always @(posedge clk)
    begin : check_beats
        sfd_pkg::result_t seen;
        sfd_pkg::result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.frame_byte = m_axis_tdata[7:0];
                seen.byte_index = m_axis_tdata[15:8];
                seen.run_last   = m_axis_tlast;
                seen.frame_end  = m_axis_tuser[0];
                seen.frame_good = m_axis_tuser[1];
                beats_checked++;
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected beat: byte %h index %0d last %b end %b good %b",
                                 $time, seen.frame_byte, seen.byte_index, seen.run_last,
                                 seen.frame_end, seen.frame_good);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (seen.frame_byte !== want.frame_byte ||
                        seen.byte_index !== want.byte_index ||
                        seen.run_last   !== want.run_last   ||
                        seen.frame_end  !== want.frame_end  ||
                        seen.frame_good !== want.frame_good)
                    begin
                        mismatches++;
                        // Fields: byte, index, then last, end and good bits
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch: expected %h/%0d/%b%b%b, got %h/%0d/%b%b%b",
                                     $time, want.frame_byte, want.byte_index, want.run_last,
                                     want.frame_end, want.frame_good, seen.frame_byte,
                                     seen.byte_index, seen.run_last, seen.frame_end,
                                     seen.frame_good);
                    end
                    if (want.frame_end)
                    begin
                        frames_ended++;
                        if (want.frame_good)
                            frames_good++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d beats still expected",
                     $time, cycle_count, expected_beats.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int      goal;
        int      pick;
        int      len;
        flaw_e   flaw;

        hunt_hist = '{default: 8'h00};
        in_frame  = 1'b0;
        frame_pos = 8'd0;
        frame_len = 8'd0;
        crc_run   = sfd_pkg::CRC_INIT;
        checks_ok = 1'b1;

        // Directed: extreme bytes, rejected headers, short frames from minimum length
        build_idle  = 0;
        build_stall = 0;
        build_drain = 1'b0;
        add_byte(8'h00);
        add_byte(8'hFF);
        add_header(8'h09, sfd_pkg::MIN_FRAME - 8'd1);
        add_header(8'h00, sfd_pkg::MAX_FRAME + 8'd1);
        add_header(sfd_pkg::HDR_ID_LIMIT, sfd_pkg::MIN_FRAME + 8'd2);
        add_frame(6, 8'h09, FLAW_NONE, 1'b0);
        add_frame(7, 8'h00, FLAW_NONE, 1'b0);

        // Random phases, each opening with a pause until the output drains
        for (int ph = 0; ph < 4; ph++)
        begin
            build_idle  = SENDER_IDLE[ph];
            build_stall = RECEIVER_STALL[ph];
            build_drain = 1'b1;
            goal = rx_stream.size() + RANDOM_BYTES / 4;
            while (rx_stream.size() < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    pick = $urandom_range(99);
                    if (pick < 80)
                        len = $urandom_range(6, 16);
                    else if (pick < 92)
                        len = $urandom_range(17, sfd_pkg::MAX_FRAME - 1);
                    else
                        len = sfd_pkg::MAX_FRAME;
                    if ($urandom_range(1))
                        flaw = FLAW_NONE;
                    else
                        flaw = flaw_e'($urandom_range(int'(FLAW_CRC_LO), int'(FLAW_PAYLOAD)));
                    add_frame(len, 8'($urandom_range(sfd_pkg::HDR_ID_LIMIT - 1)), flaw,
                              $urandom_range(99) < 15);
                end
                else if (pick < 80)
                begin
                    // Header that must be ignored: bad id or bad length
                    if ($urandom_range(1))
                        add_header(8'($urandom_range(sfd_pkg::HDR_ID_LIMIT, 255)),
                                   8'($urandom_range(sfd_pkg::MIN_FRAME, sfd_pkg::MAX_FRAME)));
                    else if ($urandom_range(1))
                        add_header(8'($urandom_range(sfd_pkg::HDR_ID_LIMIT - 1)),
                                   8'($urandom_range(sfd_pkg::MIN_FRAME - 1)));
                    else
                        add_header(8'($urandom_range(sfd_pkg::HDR_ID_LIMIT - 1)),
                                   8'($urandom_range(sfd_pkg::MAX_FRAME + 1, 255)));
                end
                else
                begin
                    // Line noise, with stray start and sync marks
                    repeat ($urandom_range(1, 6))
                    begin
                        pick = $urandom_range(9);
                        if (pick == 0)
                            add_byte(sfd_pkg::HDR_START);
                        else if (pick == 1)
                            add_byte(sfd_pkg::HDR_SYNC);
                        else
                            add_byte(8'($urandom_range(255)));
                    end
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: stream sent, every beat in, then a quiet tail for strays
        while (rx_stream.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes through four pacing phases; checked %0d output beats.",
                 bytes_accepted, beats_checked);
        $display("Frames closed: %0d, of which %0d passed CRC and tail; %0d mismatches.",
                 frames_ended, frames_good, mismatches);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sfd_pkg.sv
rtl/core/sfd_result_fifo.sv
rtl/core/sensor_frame_deframer_crc16.sv
sim/tb_sensor_frame_deframer_crc16.sv
